/* rtl/gdo_pkg.sv */
// shared types, constants and month length lookup for the date offset block
`default_nettype none

package gdo_pkg;

    localparam int YEAR_W   = 16;
    localparam int DAY_W    = 18;
    localparam int R400_W   = 9;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic signed [YEAR_W-1:0] YEAR_MIN = 16'sd1;
    localparam logic signed [YEAR_W-1:0] YEAR_MAX = 16'sd9999;

    localparam logic [R400_W-1:0] R400_LAST = 9'd399;

    localparam logic [4:0] MONTH_LEN [0:12] =
        '{5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [R400_W-1:0]        year_r400;
        logic [3:0]               month;
        logic signed [DAY_W-1:0]  day;
    } gdo_item_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        idx = (m > MONTH_DEC) ? MONTH_DEC : m;
        if (m == MONTH_FEB)
        begin
            return leap ? 5'd29 : 5'd28;
        end
        return MONTH_LEN[idx];
    endfunction

    function automatic logic is_leap(input logic [R400_W-1:0] r);
        return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

endpackage

`default_nettype wire

/* rtl/gregorian_date_offset_top.sv */
// date offset block: front stage, two-entry queue, month-stepping back stage
// a request passes the front register and the queue, then the back stage walks one month per cycle
// the back stage waits for a free output, registers the result, and only then takes a new request
// the front stage and queue keep taking requests while the back stage is busy, until both are full
// rst_n is asynchronous active low and empties all stages; no state survives a request
`default_nettype none

module gregorian_date_offset_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [13:0]        start_year,
    input  wire logic [3:0]         start_month,
    input  wire logic [4:0]         start_day,
    input  wire logic signed [16:0] offset_days,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [13:0]             result_year,
    output logic [3:0]              result_month,
    output logic [4:0]              result_day,
    output logic                    year_out_of_range
);
    import gdo_pkg::*;

    gdo_item_t push_item;
    gdo_item_t pop_item;
    logic      push_valid;
    logic      push_ready;
    logic      pop_valid;
    logic      pop;

    gdo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_year  (start_year),
        .start_month (start_month),
        .start_day   (start_day),
        .offset_days (offset_days),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    gdo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    gdo_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (pop_valid),
        .q_pop             (pop),
        .q_item            (pop_item),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_year       (result_year),
        .result_month      (result_month),
        .result_day        (result_day),
        .year_out_of_range (year_out_of_range)
    );

endmodule

`default_nettype wire

/* rtl/gdo_front.sv */
// front stage: takes requests, clamps month, sums day and offset, reduces year mod 400
`default_nettype none

module gdo_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [13:0]         start_year,
    input  wire logic [3:0]          start_month,
    input  wire logic [4:0]          start_day,
    input  wire logic signed [16:0]  offset_days,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output gdo_pkg::gdo_item_t       push_item
);
    import gdo_pkg::*;

    gdo_item_t item_reg;
    gdo_item_t item_next;
    logic      valid_reg;
    logic [13:0] rem;
    logic [13:0] step;

    always_comb
    begin
        // restoring reduction by 400 << k
        rem = start_year;
        for (int k = 5; k >= 0; k--)
        begin
            step = 14'(400 << k);
            if (rem >= step)
            begin
                rem = rem - step;
            end
        end

        item_next.year      = $signed({2'b00, start_year});
        item_next.year_r400 = rem[R400_W-1:0];
        if (start_month == 4'd0)
        begin
            item_next.month = MONTH_JAN;
        end
        else if (start_month inside {[4'd13:4'd15]})
        begin
            item_next.month = MONTH_DEC;
        end
        else
        begin
            item_next.month = start_month;
        end
        item_next.day = $signed({13'd0, start_day}) + DAY_W'(offset_days);
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/gdo_queue.sv */
// short fifo between the front and back stages
`default_nettype none

module gdo_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire gdo_pkg::gdo_item_t push_item,
    output logic               pop_valid,
    input  wire logic          pop,
    output gdo_pkg::gdo_item_t pop_item
);
    import gdo_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gdo_item_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/gdo_back.sv */
// back stage: walks one month per cycle, then saturates and registers the result once the output is free
`default_nettype none

module gdo_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire gdo_pkg::gdo_item_t q_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [13:0]             result_year,
    output logic [3:0]              result_month,
    output logic [4:0]              result_day,
    output logic                    year_out_of_range
);
    import gdo_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                   state_reg;
    logic signed [YEAR_W-1:0] year_reg;
    logic [R400_W-1:0]        r400_reg;
    logic [3:0]               month_reg;
    logic signed [DAY_W-1:0]  day_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [13:0]              res_year_reg;
    logic [3:0]               res_month_reg;
    logic [4:0]               res_day_reg;
    logic                     res_flag_reg;

    logic       leap;
    logic [4:0] cur_len;
    logic [3:0] prev_month;
    logic [4:0] prev_len;
    logic       go_fwd;
    logic       go_bwd;
    logic       out_free;
    logic       walk_done;
    logic       sat_lo;
    logic       sat_hi;

    always_comb
    begin
        leap       = is_leap(r400_reg);
        cur_len    = month_days(month_reg, leap);
        prev_month = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;
        prev_len   = month_days(prev_month, leap);
        go_fwd     = day_reg > $signed({13'd0, cur_len});
        go_bwd     = day_reg[DAY_W-1] || (day_reg == '0);
        out_free   = !out_valid_reg || out_ready;
        walk_done  = (state_reg == ST_RUN) && !go_fwd && !go_bwd && out_free;
        sat_lo     = year_reg < YEAR_MIN;
        sat_hi     = year_reg > YEAR_MAX;
        out_valid_next = out_valid_reg && !out_ready;
        if (walk_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign q_pop             = (state_reg == ST_IDLE) && q_valid;
    assign out_valid         = out_valid_reg;
    assign result_year       = res_year_reg;
    assign result_month      = res_month_reg;
    assign result_day        = res_day_reg;
    assign year_out_of_range = res_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (walk_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            if (q_valid)
            begin
                year_reg  <= q_item.year;
                r400_reg  <= q_item.year_r400;
                month_reg <= q_item.month;
                day_reg   <= q_item.day;
            end
        end
        else if (go_fwd)
        begin
            day_reg <= day_reg - $signed({13'd0, cur_len});
            if (month_reg == MONTH_DEC)
            begin
                month_reg <= MONTH_JAN;
                year_reg  <= year_reg + 16'sd1;
                r400_reg  <= (r400_reg == R400_LAST) ? '0 : r400_reg + 9'd1;
            end
            else
            begin
                month_reg <= month_reg + 4'd1;
            end
        end
        else if (go_bwd)
        begin
            day_reg   <= day_reg + $signed({13'd0, prev_len});
            month_reg <= prev_month;
            if (month_reg == MONTH_JAN)
            begin
                year_reg <= year_reg - 16'sd1;
                r400_reg <= (r400_reg == '0) ? R400_LAST : r400_reg - 9'd1;
            end
        end
        else if (out_free)
        begin
            if (sat_lo)
            begin
                res_year_reg  <= YEAR_MIN[13:0];
                res_month_reg <= MONTH_JAN;
                res_day_reg   <= 5'd1;
                res_flag_reg  <= 1'b1;
            end
            else if (sat_hi)
            begin
                res_year_reg  <= YEAR_MAX[13:0];
                res_month_reg <= MONTH_DEC;
                res_day_reg   <= 5'd31;
                res_flag_reg  <= 1'b1;
            end
            else
            begin
                res_year_reg  <= year_reg[13:0];
                res_month_reg <= month_reg;
                res_day_reg   <= day_reg[4:0];
                res_flag_reg  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* bench/tb_gregorian_date_offset_top.sv */
// self-checking testbench for gregorian_date_offset_top: directed table, random dates, stalls
`timescale 1ns / 1ps

module tb_gregorian_date_offset_top;

    localparam int YEAR_FIRST      = 1;
    localparam int YEAR_LAST       = 9999;
    localparam int RANDOM_ITEMS    = 245;
    localparam int HOLD_OFF_CYCLES = 8000;
    localparam int DRAIN_CYCLES    = 2200;
    localparam int CYCLE_LIMIT     = 4000000;
    localparam int PRINT_LIMIT     = 50;

    localparam logic signed [16:0] OFFSET_MIN = 17'h10000;
    localparam logic signed [16:0] OFFSET_MAX = 17'sd65535;

    localparam int DAYS_PER_MONTH [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        out_of_range;
    } date_result_t;

    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [16:0] offset;
        logic               typed;
        date_result_t       want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;

    // typed rows: identity, saturation at both ends, out-of-range start years
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{14'd2000, 4'd1, 5'd1, 17'sd0, 1'b1, '{14'd2000, 4'd1, 5'd1, 1'b0}},
        '{14'd9999, 4'd12, 5'd31, 17'sd1, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
        '{14'd1, 4'd1, 5'd1, -17'sd1, 1'b1, '{14'd1, 4'd1, 5'd1, 1'b1}},
        '{14'd9999, 4'd12, 5'd31, OFFSET_MAX, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
        '{14'd1, 4'd1, 5'd1, OFFSET_MIN, 1'b1, '{14'd1, 4'd1, 5'd1, 1'b1}},
        '{14'd16383, 4'd15, 5'd31, 17'sd0, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b1}},
        '{14'd0, 4'd3, 5'd1, -17'sd1, 1'b1, '{14'd1, 4'd1, 5'd1, 1'b1}},
        '{14'd9999, 4'd12, 5'd31, 17'sd0, 1'b1, '{14'd9999, 4'd12, 5'd31, 1'b0}},
        '{14'd1, 4'd1, 5'd1, 17'sd0, 1'b1, '{14'd1, 4'd1, 5'd1, 1'b0}},
        '{14'd0, 4'd12, 5'd31, 17'sd1, 1'b0, '0},
        '{14'd2000, 4'd2, 5'd28, 17'sd1, 1'b0, '0},
        '{14'd1900, 4'd2, 5'd28, 17'sd1, 1'b0, '0},
        '{14'd2100, 4'd2, 5'd28, 17'sd1, 1'b0, '0},
        '{14'd2024, 4'd3, 5'd1, -17'sd1, 1'b0, '0},
        '{14'd2020, 4'd0, 5'd15, 17'sd0, 1'b0, '0},
        '{14'd2020, 4'd15, 5'd31, 17'sd0, 1'b0, '0},
        '{14'd2020, 4'd13, 5'd5, -17'sd10, 1'b0, '0},
        '{14'd2021, 4'd3, 5'd0, 17'sd0, 1'b0, '0},
        '{14'd2021, 4'd2, 5'd31, 17'sd0, 1'b0, '0},
        '{14'd2023, 4'd1, 5'd0, 17'sd0, 1'b0, '0},
        '{14'd1, 4'd1, 5'd1, OFFSET_MAX, 1'b0, '0},
        '{14'd9999, 4'd1, 5'd1, OFFSET_MIN, 1'b0, '0},
        '{14'd5000, 4'd6, 5'd15, OFFSET_MIN, 1'b0, '0},
        '{14'd2400, 4'd2, 5'd29, 17'sd365, 1'b0, '0},
        '{14'd0, 4'd0, 5'd0, 17'sd0, 1'b0, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_ready;
    logic [13:0]        start_year;
    logic [3:0]         start_month;
    logic [4:0]         start_day;
    logic signed [16:0] offset_days;
    logic               out_valid;
    logic               out_ready;
    logic [13:0]        result_year;
    logic [3:0]         result_month;
    logic [4:0]         result_day;
    logic               year_out_of_range;

    date_result_t expected_dates [$];
    date_result_t oldest_date;
    int           error_count = 0;
    int           cycle_count = 0;
    int           phase = 0;
    int           send_idle_pct = 20;
    int           recv_idle_pct = 58;
    logic         hold_done = 1'b0;
    int           hold_cycles;

    gregorian_date_offset_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .start_year        (start_year),
        .start_month       (start_month),
        .start_day         (start_day),
        .offset_days       (offset_days),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_year       (result_year),
        .result_month      (result_month),
        .result_day        (result_day),
        .year_out_of_range (year_out_of_range)
    );

    always #2 clk = ~clk;

    function automatic int month_length(input int m, input int y);
        if (m == 2)
        begin
            return (((y % 100 != 0) && (y % 4 == 0)) || (y % 400 == 0)) ? 29 : 28;
        end
        return DAYS_PER_MONTH[m];
    endfunction

    function automatic date_result_t advance_date(input logic [13:0] y_in, input logic [3:0] m_in,
                                                  input logic [4:0] d_in,
                                                  input logic signed [16:0] off);
        int           y;
        int           m;
        int           d;
        date_result_t r;
        y = int'(y_in);
        m = int'(m_in);
        d = int'(d_in) + int'(off);
        if (m < 1)
        begin
            m = 1;
        end
        if (m > 12)
        begin
            m = 12;
        end
        while (d > month_length(m, y))
        begin
            d -= month_length(m, y);
            m++;
            if (m > 12)
            begin
                m = 1;
                y++;
            end
        end
        while (d <= 0)
        begin
            m--;
            if (m == 0)
            begin
                m = 12;
                y--;
            end
            d += month_length(m, y);
        end
        r.out_of_range = 1'b0;
        if (y < YEAR_FIRST)
        begin
            r.out_of_range = 1'b1;
            y = YEAR_FIRST;
            m = 1;
            d = 1;
        end
        else if (y > YEAR_LAST)
        begin
            r.out_of_range = 1'b1;
            y = YEAR_LAST;
            m = 12;
            d = 31;
        end
        r.year  = y[13:0];
        r.month = m[3:0];
        r.day   = d[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_LIMIT)
        begin
            $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                     cycle_count);
        end
        error_count++;
    endtask

    task automatic offer_request(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                                 input logic signed [16:0] off, input logic typed,
                                 input date_result_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        start_year  <= y;
        start_month <= m;
        start_day   <= d;
        offset_days <= off;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_dates.push_back(typed ? want : advance_date(y, m, d, off));
    endtask

    task automatic random_request(output logic [13:0] y, output logic [3:0] m,
                                  output logic [4:0] d, output logic signed [16:0] off);
        int sel;
        int yr;
        int mo;
        int span;
        sel = $urandom_range(99);
        if (sel < 80)
        begin
            sel = $urandom_range(9);
            if (sel == 0)
            begin
                yr = $urandom_range(3, 1);
            end
            else if (sel == 1)
            begin
                yr = $urandom_range(9999, 9997);
            end
            else
            begin
                yr = $urandom_range(9999, 1);
            end
            mo = $urandom_range(12, 1);
            y  = yr[13:0];
            m  = mo[3:0];
            d  = 5'($urandom_range(month_length(mo, yr), 1));
            sel = $urandom_range(99);
            if (sel < 55)
            begin
                span = $urandom_range(120);
            end
            else if (sel < 85)
            begin
                span = $urandom_range(3000);
            end
            else
            begin
                span = -1;
            end
            if (span < 0)
            begin
                off = 17'($urandom);
            end
            else
            begin
                off = ($urandom_range(1) == 1) ? 17'(-span) : 17'(span);
            end
        end
        else
        begin
            y   = 14'($urandom);
            m   = 4'($urandom);
            d   = 5'($urandom);
            off = 17'($urandom);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_gregorian_date_offset_top: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                report_mismatch("unexpected result, year", result_year, 0);
            end
            else
            begin
                oldest_date = expected_dates.pop_front();
                if (result_year != oldest_date.year)
                begin
                    report_mismatch("result_year", result_year, oldest_date.year);
                end
                if (result_month != oldest_date.month)
                begin
                    report_mismatch("result_month", result_month, oldest_date.month);
                end
                if (result_day != oldest_date.day)
                begin
                    report_mismatch("result_day", result_day, oldest_date.day);
                end
                if (year_out_of_range != oldest_date.out_of_range)
                begin
                    report_mismatch("year_out_of_range", year_out_of_range,
                                    oldest_date.out_of_range);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off at the start of the last phase
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (phase == 2 && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_OFF_CYCLES)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        logic [13:0]        y;
        logic [3:0]         m;
        logic [4:0]         d;
        logic signed [16:0] off;
        in_valid    = 1'b0;
        start_year  = '0;
        start_month = '0;
        start_day   = '0;
        offset_days = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            offer_request(DIRECTED[i].year, DIRECTED[i].month, DIRECTED[i].day,
                          DIRECTED[i].offset, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase = (i * 3) / RANDOM_ITEMS;
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            random_request(y, m, d, off);
            offer_request(y, m, d, off, 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb_gregorian_date_offset_top: clean");
        end
        else
        begin
            $display("tb_gregorian_date_offset_top: errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gdo_pkg.sv
rtl/gdo_front.sv
rtl/gdo_queue.sv
rtl/gdo_back.sv
rtl/gregorian_date_offset_top.sv
bench/tb_gregorian_date_offset_top.sv
